// File: design/sarp_pkg.sv
`timescale 1ns / 1ps

package sarp_pkg;

    // Defaults for the top-level parameters.
    localparam int CAPTURE_LIMIT_DEF = 4095;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Fixed sizes of the record format.
    localparam int VALUE_W           = 16;
    localparam int NUM_VALUES        = 7;
    localparam int NUM_FIELDS        = 13;
    localparam int FIRST_VALUE_FIELD = 6;
    localparam int FIELD_W           = 4;

    localparam logic [VALUE_W-1:0] SIGNAL_MAX_RESET = 16'd4130;
    localparam logic [VALUE_W-1:0] SAT_MAX          = 16'hFFFF;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_COLON = 8'd58;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_BYTE    = 2'd1,
        OP_COLLECT = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        KIND_NUL,
        KIND_EOL,
        KIND_DIGIT,
        KIND_WS,
        KIND_SLASH,
        KIND_COLON,
        KIND_OTHER
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_BYTES = 3'd1,
        ST_NO_ROW   = 3'd2,
        ST_FORMAT   = 3'd3,
        ST_OVER     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ROW_NONE,
        ROW_OK,
        ROW_BAD
    } t_row;

    typedef enum logic [1:0] {
        PH_START,
        PH_DIGIT,
        PH_OTHER
    } t_phase;

    // One classified request as it travels through the queue.
    typedef struct packed {
        t_op        op;
        t_kind      kind;
        logic [3:0] digit;
    } t_cmd;

    // One collect result: the values, channel one wavelength in the lowest bits.
    typedef struct packed {
        t_status                           status;
        logic [NUM_VALUES-1:0][VALUE_W-1:0] vals;
    } t_result;

endpackage

// File: design/sarp_front.sv
`timescale 1ns / 1ps

module sarp_front (
    input  logic              i_valid,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_byte,
    input  logic              i_full,
    output logic              o_ready,
    output logic              o_push,
    output sarp_pkg::t_cmd    o_cmd
);
    import sarp_pkg::*;

    logic is_known_op;

    // Unused opcodes are taken and dropped without reaching the queue.
    assign is_known_op = (i_opcode == OP_CLEAR) || (i_opcode == OP_BYTE)
                      || (i_opcode == OP_COLLECT);
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full && is_known_op;

    // Classify the byte so the back end only looks at a small code.
    always_comb begin
        o_cmd.op    = t_op'(i_opcode);
        o_cmd.digit = i_byte[3:0];
        if (i_byte == CH_NUL) begin
            o_cmd.kind = KIND_NUL;
        end else if (i_byte == CH_CR || i_byte == CH_LF) begin
            o_cmd.kind = KIND_EOL;
        end else if (i_byte >= CH_ZERO && i_byte <= CH_NINE) begin
            o_cmd.kind = KIND_DIGIT;
        end else if (i_byte == CH_SPACE || i_byte == CH_TAB || i_byte == CH_VT
                     || i_byte == CH_FF) begin
            o_cmd.kind = KIND_WS;
        end else if (i_byte == CH_SLASH) begin
            o_cmd.kind = KIND_SLASH;
        end else if (i_byte == CH_COLON) begin
            o_cmd.kind = KIND_COLON;
        end else begin
            o_cmd.kind = KIND_OTHER;
        end
    end

endmodule

// File: design/sarp_queue.sv
`timescale 1ns / 1ps

module sarp_queue #(
    parameter int QUEUE_DEPTH = sarp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sarp_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output sarp_pkg::t_cmd o_cmd
);
    import sarp_pkg::*;

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [ADDR_W:0]   r_wr_ptr;
    logic [ADDR_W:0]   r_rd_ptr;
    logic [ADDR_W:0]   count;

    assign count   = r_wr_ptr - r_rd_ptr;
    assign o_full  = (count == (ADDR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_wr_ptr != r_rd_ptr);
    assign o_cmd   = r_mem[r_rd_ptr[ADDR_W-1:0]];

    // Storage is written at the tail; no reset needed for payload.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[ADDR_W-1:0]] <= i_cmd;
        end
    end

    // Pointers carry one extra bit to tell full from empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= (ADDR_W+1)'(QUEUE_DEPTH))
        else $error("queue holds more requests than its depth");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue popped while empty");

endmodule

// File: design/sarp_back.sv
`timescale 1ns / 1ps

module sarp_back #(
    parameter int CAPTURE_LIMIT = sarp_pkg::CAPTURE_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [sarp_pkg::VALUE_W-1:0]    i_cfg_wr_data,
    input  logic                            i_q_valid,
    input  sarp_pkg::t_cmd                  i_q_cmd,
    output logic                            o_q_pop,
    output logic                            o_res_valid,
    output sarp_pkg::t_result               o_res,
    input  logic                            i_res_ready
);
    import sarp_pkg::*;

    localparam int CNT_W = $clog2(CAPTURE_LIMIT + 1);
    localparam logic [CNT_W-1:0]   LIMIT      = CNT_W'(CAPTURE_LIMIT);
    localparam logic [FIELD_W-1:0] LAST_FIELD = FIELD_W'(NUM_FIELDS);

    // Parser state.
    logic [VALUE_W-1:0]              r_signal_max;
    logic [CNT_W-1:0]                r_byte_count, n_byte_count;
    logic                            r_have_data, n_have_data;
    t_phase                          r_phase, n_phase;
    logic [FIELD_W-1:0]              r_field_num, n_field_num;
    logic [VALUE_W-1:0]              r_acc, n_acc;
    logic                            r_seen, n_seen;
    logic                            r_bad, n_bad;
    logic [NUM_VALUES-1:0][VALUE_W-1:0] r_line_vals, n_line_vals;
    logic [NUM_VALUES-1:0][VALUE_W-1:0] r_row_vals, n_row_vals;
    t_row                            r_row_state, n_row_state;

    // Output register.
    logic                            r_out_valid;
    t_result                         r_out;

    logic                            load_out;
    logic                            do_end;
    logic [FIELD_W-1:0]              field_inc;
    logic [FIELD_W-1:0]              field_eff;
    logic [FIELD_W-1:0]              field_after;
    logic [VALUE_W+3:0]              acc_wide;
    logic [VALUE_W-1:0]              acc_digit;
    logic                            over_limit;
    t_status                         status;
    t_result                         result;

    // Next accumulator value for a decimal digit, saturating.
    assign acc_wide  = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1)
                     + {16'd0, i_q_cmd.digit};
    assign acc_digit = (acc_wide > {4'd0, SAT_MAX}) ? SAT_MAX : acc_wide[VALUE_W-1:0];
    assign field_inc = r_field_num + 1'b1;

    // Status and values for a collect request.
    always_comb begin
        over_limit = (r_row_vals[1] > r_signal_max) || (r_row_vals[3] > r_signal_max)
                  || (r_row_vals[5] > r_signal_max);
        if (!r_have_data) begin
            status = ST_NO_BYTES;
        end else if (r_row_state == ROW_NONE) begin
            status = ST_NO_ROW;
        end else if (r_row_state != ROW_OK) begin
            status = ST_FORMAT;
        end else if (over_limit) begin
            status = ST_OVER;
        end else begin
            status = ST_OK;
        end
        result.status = status;
        result.vals   = (status == ST_OK) ? r_row_vals : '0;
    end

    // One request from the queue is carried out per cycle while no collect waits.
    always_comb begin
        n_byte_count = r_byte_count;
        n_have_data  = r_have_data;
        n_phase      = r_phase;
        n_field_num  = r_field_num;
        n_acc        = r_acc;
        n_seen       = r_seen;
        n_bad        = r_bad;
        n_line_vals  = r_line_vals;
        n_row_vals   = r_row_vals;
        n_row_state  = r_row_state;
        o_q_pop      = 1'b0;
        load_out     = 1'b0;
        do_end       = 1'b0;
        field_eff    = r_field_num;
        field_after  = field_inc;

        if (i_q_valid) begin
            case (i_q_cmd.op)
                OP_CLEAR: begin
                    o_q_pop      = 1'b1;
                    n_byte_count = '0;
                    n_have_data  = 1'b0;
                    n_phase      = PH_START;
                    n_field_num  = '0;
                    n_acc        = '0;
                    n_seen       = 1'b0;
                    n_bad        = 1'b0;
                    n_row_state  = ROW_NONE;
                end
                OP_BYTE: begin
                    o_q_pop = 1'b1;
                    if (r_byte_count < LIMIT) begin
                        n_byte_count = r_byte_count + 1'b1;
                        if (i_q_cmd.kind != KIND_NUL) begin
                            n_have_data = 1'b1;
                            if (i_q_cmd.kind == KIND_EOL) begin
                                // End of line: a digit line becomes the latest row.
                                if (r_phase == PH_DIGIT) begin
                                    do_end = !r_bad && r_seen && (r_field_num < LAST_FIELD);
                                    if (do_end) begin
                                        for (int k = 0; k < NUM_VALUES; k++) begin
                                            if (r_field_num == FIELD_W'(k + FIRST_VALUE_FIELD)) begin
                                                n_line_vals[k] = r_acc;
                                            end
                                        end
                                        field_eff   = field_inc;
                                        n_field_num = field_inc;
                                        n_acc       = '0;
                                        n_seen      = 1'b0;
                                    end
                                    n_row_vals  = n_line_vals;
                                    n_row_state = (!r_bad && field_eff >= LAST_FIELD)
                                                ? ROW_OK : ROW_BAD;
                                end
                                n_phase = PH_START;
                            end else if (r_phase == PH_START) begin
                                if (i_q_cmd.kind == KIND_DIGIT) begin
                                    n_phase     = PH_DIGIT;
                                    n_field_num = '0;
                                    n_acc       = {12'd0, i_q_cmd.digit};
                                    n_seen      = 1'b1;
                                    n_bad       = 1'b0;
                                end else begin
                                    n_phase = PH_OTHER;
                                end
                            end else if (r_phase == PH_DIGIT && !r_bad
                                         && r_field_num < LAST_FIELD) begin
                                // Inside a record line: numbers and separators.
                                if (i_q_cmd.kind == KIND_DIGIT) begin
                                    n_acc  = acc_digit;
                                    n_seen = 1'b1;
                                end else if (r_seen) begin
                                    for (int k = 0; k < NUM_VALUES; k++) begin
                                        if (r_field_num == FIELD_W'(k + FIRST_VALUE_FIELD)) begin
                                            n_line_vals[k] = r_acc;
                                        end
                                    end
                                    n_field_num = field_inc;
                                    n_acc       = '0;
                                    n_seen      = 1'b0;
                                    if (field_after < LAST_FIELD) begin
                                        if (field_after == 4'd1 || field_after == 4'd2) begin
                                            n_bad = (i_q_cmd.kind != KIND_SLASH);
                                        end else if (field_after == 4'd4
                                                     || field_after == 4'd5) begin
                                            n_bad = (i_q_cmd.kind != KIND_COLON);
                                        end else begin
                                            n_bad = (i_q_cmd.kind != KIND_WS);
                                        end
                                    end
                                end else if (i_q_cmd.kind != KIND_WS) begin
                                    n_bad = 1'b1;
                                end
                            end
                        end
                    end
                end
                OP_COLLECT: begin
                    // A collect waits until the output register can take it.
                    if (!r_out_valid || i_res_ready) begin
                        o_q_pop  = 1'b1;
                        load_out = 1'b1;
                    end
                end
                default: begin
                    o_q_pop = 1'b1;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signal_max <= SIGNAL_MAX_RESET;
            r_byte_count <= '0;
            r_have_data  <= 1'b0;
            r_phase      <= PH_START;
            r_field_num  <= '0;
            r_acc        <= '0;
            r_seen       <= 1'b0;
            r_bad        <= 1'b0;
            r_row_state  <= ROW_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_signal_max <= i_cfg_wr_data;
            end
            r_byte_count <= n_byte_count;
            r_have_data  <= n_have_data;
            r_phase      <= n_phase;
            r_field_num  <= n_field_num;
            r_acc        <= n_acc;
            r_seen       <= n_seen;
            r_bad        <= n_bad;
            r_row_state  <= n_row_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stored values and the result payload.
    always_ff @(posedge i_clk) begin
        r_line_vals <= n_line_vals;
        r_row_vals  <= n_row_vals;
        if (load_out) begin
            r_out <= result;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    a_field_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_field_num <= LAST_FIELD)
        else $error("field number ran past the last field");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= LIMIT)
        else $error("byte count ran past the capture limit");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_cmd.op == OP_CLEAR)
        |=> (r_row_state == ROW_NONE && !r_have_data && r_byte_count == '0))
        else $error("clear request left capture state behind");

    a_ok_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && status == ST_OK) |-> (r_row_state == ROW_OK
            && r_row_vals[1] <= r_signal_max && r_row_vals[3] <= r_signal_max
            && r_row_vals[5] <= r_signal_max))
        else $error("ok status given for a row that fails the checks");

endmodule

// File: design/sensor_ascii_record_parser_unit.sv
`timescale 1ns / 1ps

// Fluorometer record parser. The slave stream carries one request per beat:
// s_axis_tuser holds the opcode (clear and arm, received byte, collect) and
// s_axis_tdata the received byte. Only a collect request makes a result on the
// master stream: m_axis_tuser holds the status and m_axis_tdata the seven
// values of the latest complete record line, zero unless the status is ok.
// The signal limit is written through i_cfg_wr_en / i_cfg_wr_data while idle;
// the user must keep to this, the block itself does not enforce it. Throughput
// is one request per cycle while no collect waits on a stalled receiver: the
// back end carries out one request from the queue in each cycle, one parse step
// per byte. A collect request passes through the queue and then loads the
// output register, which holds the result for the master stream.
// When the receiver stalls, the result waits in the output register; bytes and
// clears keep being processed until a collect reaches the head of the queue,
// and s_axis_tready drops once the queue is full.
// Reset is synchronous: it empties the queue, clears the capture state and
// sets the signal limit to 4130. No clearing pass is needed after reset.
module sensor_ascii_record_parser_unit #(
    parameter int CAPTURE_LIMIT = sarp_pkg::CAPTURE_LIMIT_DEF,
    parameter int QUEUE_DEPTH   = sarp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [15:0]                  i_cfg_wr_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] byte_value
    input  logic [1:0]                   s_axis_tuser,   // [1:0] opcode
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [15:0] ch1_wavelength, [31:16] ch1_count, [47:32] ch2_wavelength,
    // [63:48] ch2_count, [79:64] ch3_wavelength, [95:80] ch3_count,
    // [111:96] thermistor
    output logic [111:0]                 m_axis_tdata,
    output logic [2:0]                   m_axis_tuser    // [2:0] status
);
    import sarp_pkg::*;

    logic    full;
    logic    push;
    t_cmd    push_cmd;
    logic    q_valid;
    t_cmd    q_cmd;
    logic    q_pop;
    logic    res_valid;
    t_result res;

    // Front end: accept and classify requests.
    sarp_front u_front (
        .i_valid  (s_axis_tvalid),
        .i_opcode (s_axis_tuser),
        .i_byte   (s_axis_tdata),
        .i_full   (full),
        .o_ready  (s_axis_tready),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // Request queue between the two halves.
    sarp_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Back end: parser state and the output register.
    sarp_back #(
        .CAPTURE_LIMIT (CAPTURE_LIMIT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .i_res_ready   (m_axis_tready)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = res.vals;
    assign m_axis_tuser  = res.status;

endmodule
